// ===== hw/rtl/dlu_pkg.sv =====
// ----------------------------------------------------------------------------
// LU decomposition package
// Shared fixed point widths and data types of the LU decomposition block.
// ----------------------------------------------------------------------------
package dlu_pkg;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int PROD_W = 2 * DATA_W;
   localparam int RND_W  = PROD_W - FRAC_W;
   localparam int ACC_W  = 52;
   localparam int QUO_W  = DATA_W + FRAC_W;

   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(64'sd32768);
   localparam logic signed [DATA_W-1:0] DATA_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] DATA_MIN   = 32'sh8000_0000;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic        [3:0]        size_type;

endpackage

// ===== hw/rtl/doolittle_lu_decompose_top.sv =====
// ----------------------------------------------------------------------------
// Doolittle LU decomposition
// Loads a square Q16.16 matrix, factors it in place without pivoting and
// streams out U on and above the diagonal and L below it.
// ----------------------------------------------------------------------------
// The block takes one matrix entry per cycle in row-major order. After the
// last entry it stops taking requests and factors the matrix with one shared
// multiplier and one bit-serial divider, then emits each entry through a read
// state and an output state that waits while rsp_stall is high. A U entry runs
// a multiply-accumulate pass over its product terms, and an L entry adds its
// 48-step restoring division, which dominates. Loading of the next matrix
// starts while the last result still waits in the output register.
module doolittle_lu_decompose_top #(
   parameter int MAX_SIDE = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  dlu_pkg::size_type csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  dlu_pkg::data_type req_element,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dlu_pkg::data_type rsp_value,
   output logic [2:0]        rsp_row,
   output logic [2:0]        rsp_column,
   output logic              rsp_last,
   output logic              rsp_zero_pivot,
   output logic              rsp_overflow
);
   import dlu_pkg::*;

   localparam int IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(QUO_W);

   localparam logic [3:0] ST_LOAD   = 4'd0;
   localparam logic [3:0] ST_ENTRY  = 4'd1;
   localparam logic [3:0] ST_MAC    = 4'd2;
   localparam logic [3:0] ST_SAT    = 4'd3;
   localparam logic [3:0] ST_DIVSET = 4'd4;
   localparam logic [3:0] ST_DIV    = 4'd5;
   localparam logic [3:0] ST_DIVEND = 4'd6;
   localparam logic [3:0] ST_OUTRD  = 4'd7;
   localparam logic [3:0] ST_OUTWR  = 4'd8;

   function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                               input logic [IDX_W-1:0] c);
      return AW'(r) * AW'(MAX_SIDE) + AW'(c);
   endfunction

   data_type mem [DEPTH];
   logic              wr_en, rd_en_a, rd_en_b;
   logic [AW-1:0]     wr_addr, rd_addr_a, rd_addr_b;
   data_type          wr_data;
   data_type          rdata_a_ff, rdata_b_ff;

   logic [3:0]        state_ff, state_in;
   size_type          size_ff, size_in;
   logic [IDX_W-1:0]  ld_row_ff, ld_row_in, ld_col_ff, ld_col_in;
   logic [IDX_W-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in, terms_ff, terms_in;
   logic [IDX_W-1:0]  orow_ff, orow_in, ocol_ff, ocol_in;
   logic              first_ff, first_in, rd_vld_ff, rd_vld_in;
   logic              prod_vld_ff, prod_vld_in;
   prod_type          prod_ff, prod_in;
   acc_type           acc_ff, acc_in;
   data_type          num_ff, num_in;
   logic [QUO_W-1:0]  qd_ff, qd_in;
   logic [DATA_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              piv_err_ff, piv_err_in, sat_ff, sat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   data_type          rsp_value_ff, rsp_value_in;
   logic [IDX_W-1:0]  rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic              rsp_last_ff, rsp_last_in, rsp_zp_ff, rsp_zp_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   size_type          side_w;
   logic [IDX_W-1:0]  side_last;
   prod_type          prod_rnd;
   logic signed [RND_W-1:0] rnd;
   logic              acc_ovf;
   data_type          acc_sat;
   logic [DATA_W-1:0] num_mag, piv_mag;
   logic [DATA_W:0]   rem_sh, rem_diff;
   logic              rem_ge;
   logic              quo_ovf;
   data_type          quo_sat;
   logic              adv;

   always_comb begin
      if (size_ff == 4'd0) begin
         side_w = 4'd1;
      end else if (size_ff > 4'(MAX_SIDE)) begin
         side_w = 4'(MAX_SIDE);
      end else begin
         side_w = size_ff;
      end
      side_last = IDX_W'(side_w - 4'd1);
   end

   assign prod_rnd = prod_ff + ROUND_BIAS;
   assign rnd      = prod_rnd[PROD_W-1:FRAC_W];

   assign acc_ovf = !((&acc_ff[ACC_W-1:DATA_W-1]) || !(|acc_ff[ACC_W-1:DATA_W-1]));
   assign acc_sat = acc_ovf ? (acc_ff[ACC_W-1] ? DATA_MIN : DATA_MAX) : acc_ff[DATA_W-1:0];

   assign num_mag = num_ff[DATA_W-1] ? (~num_ff + 1'b1) : num_ff;
   assign piv_mag = rdata_a_ff[DATA_W-1] ? (~rdata_a_ff + 1'b1) : rdata_a_ff;

   assign rem_sh   = {rem_ff, qd_ff[QUO_W-1]};
   assign rem_ge   = rem_sh >= {1'b0, dvs_ff};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      if (!neg_ff) begin
         quo_ovf = qd_ff > QUO_W'(DATA_MAX);
         quo_sat = quo_ovf ? DATA_MAX : qd_ff[DATA_W-1:0];
      end else begin
         quo_ovf = qd_ff > {{(QUO_W-DATA_W){1'b0}}, DATA_MIN};
         quo_sat = quo_ovf ? DATA_MIN : (~qd_ff[DATA_W-1:0] + 1'b1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      ld_row_in    = ld_row_ff;
      ld_col_in    = ld_col_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      terms_in     = terms_ff;
      orow_in      = orow_ff;
      ocol_in      = ocol_ff;
      first_in     = first_ff;
      rd_vld_in    = 1'b0;
      prod_vld_in  = rd_vld_ff;
      prod_in      = prod_type'(rdata_a_ff) * prod_type'(rdata_b_ff);
      acc_in       = acc_ff;
      num_in       = num_ff;
      qd_in        = qd_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      piv_err_in   = piv_err_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_zp_in    = rsp_zp_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = cell_addr(i_ff, j_ff);
      wr_data      = acc_sat;
      rd_en_a      = 1'b0;
      rd_addr_a    = cell_addr(i_ff, j_ff);
      rd_en_b      = 1'b0;
      rd_addr_b    = cell_addr(k_ff, j_ff);
      adv          = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               wr_en   = 1'b1;
               wr_addr = cell_addr(ld_row_ff, ld_col_ff);
               wr_data = req_element;
               if (ld_row_ff == '0 && ld_col_ff == '0) begin
                  piv_err_in = 1'b0;
                  sat_in     = 1'b0;
               end
               if (ld_col_ff == side_last) begin
                  ld_col_in = '0;
                  if (ld_row_ff == side_last) begin
                     ld_row_in = '0;
                     i_in      = '0;
                     j_in      = '0;
                     state_in  = ST_ENTRY;
                  end else begin
                     ld_row_in = ld_row_ff + 1'b1;
                  end
               end else begin
                  ld_col_in = ld_col_ff + 1'b1;
               end
            end
         end
         ST_ENTRY: begin
            rd_en_a  = 1'b1;
            k_in     = '0;
            terms_in = (i_ff < j_ff) ? i_ff : j_ff;
            first_in = 1'b1;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (first_ff) begin
               acc_in   = ACC_W'(rdata_a_ff);
               first_in = 1'b0;
            end else if (prod_vld_ff) begin
               acc_in = acc_ff - ACC_W'(rnd);
            end
            if (k_ff != terms_ff) begin
               rd_en_a   = 1'b1;
               rd_addr_a = cell_addr(i_ff, k_ff);
               rd_en_b   = 1'b1;
               k_in      = k_ff + 1'b1;
               rd_vld_in = 1'b1;
            end else if (!first_ff && !rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            sat_in = sat_ff | acc_ovf;
            if (i_ff <= j_ff) begin
               wr_en = 1'b1;
               if (i_ff == j_ff && acc_sat == '0) begin
                  piv_err_in = 1'b1;
               end
               adv = 1'b1;
            end else begin
               num_in    = acc_sat;
               rd_en_a   = 1'b1;
               rd_addr_a = cell_addr(j_ff, j_ff);
               state_in  = ST_DIVSET;
            end
         end
         ST_DIVSET: begin
            if (rdata_a_ff == '0) begin
               piv_err_in = 1'b1;
               wr_en      = 1'b1;
               wr_data    = '0;
               adv        = 1'b1;
            end else begin
               dvs_in   = piv_mag;
               neg_in   = num_ff[DATA_W-1] ^ rdata_a_ff[DATA_W-1];
               qd_in    = {num_mag, {FRAC_W{1'b0}}};
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            qd_in  = {qd_ff[QUO_W-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               state_in = ST_DIVEND;
            end
         end
         ST_DIVEND: begin
            sat_in  = sat_ff | quo_ovf;
            wr_en   = 1'b1;
            wr_data = quo_sat;
            adv     = 1'b1;
         end
         ST_OUTRD: begin
            rd_en_a   = 1'b1;
            rd_addr_a = cell_addr(orow_ff, ocol_ff);
            state_in  = ST_OUTWR;
         end
         ST_OUTWR: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rdata_a_ff;
               rsp_row_in   = orow_ff;
               rsp_col_in   = ocol_ff;
               rsp_last_in  = (orow_ff == side_last) && (ocol_ff == side_last);
               rsp_zp_in    = piv_err_ff;
               rsp_ovf_in   = sat_ff;
               state_in     = ST_OUTRD;
               if (ocol_ff == side_last) begin
                  ocol_in = '0;
                  if (orow_ff == side_last) begin
                     orow_in  = '0;
                     state_in = ST_LOAD;
                  end else begin
                     orow_in = orow_ff + 1'b1;
                  end
               end else begin
                  ocol_in = ocol_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (adv) begin
         state_in = ST_ENTRY;
         if (i_ff == side_last) begin
            i_in = '0;
            if (j_ff == side_last) begin
               orow_in  = '0;
               ocol_in  = '0;
               state_in = ST_OUTRD;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end else begin
            i_in = i_ff + 1'b1;
         end
      end

      if (csr_write_enable) begin
         size_in    = csr_write_data;
         ld_row_in  = '0;
         ld_col_in  = '0;
         piv_err_in = 1'b0;
         sat_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rdata_a_ff <= mem[rd_addr_a];
      end
      if (rd_en_b) begin
         rdata_b_ff <= mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         size_ff      <= 4'd8;
         ld_row_ff    <= '0;
         ld_col_ff    <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         terms_ff     <= '0;
         orow_ff      <= '0;
         ocol_ff      <= '0;
         first_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         cnt_ff       <= '0;
         piv_err_ff   <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         ld_row_ff    <= ld_row_in;
         ld_col_ff    <= ld_col_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         terms_ff     <= terms_in;
         orow_ff      <= orow_in;
         ocol_ff      <= ocol_in;
         first_ff     <= first_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         cnt_ff       <= cnt_in;
         piv_err_ff   <= piv_err_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      num_ff       <= num_in;
      qd_ff        <= qd_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      neg_ff       <= neg_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_zp_ff    <= rsp_zp_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign req_stall      = (state_ff != ST_LOAD);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_row        = 3'(rsp_row_ff);
   assign rsp_column     = 3'(rsp_col_ff);
   assign rsp_last       = rsp_last_ff;
   assign rsp_zero_pivot = rsp_zp_ff;
   assign rsp_overflow   = rsp_ovf_ff;

endmodule
